// File: sv/quad_stepped_slew_fader_macros.svh
// Assertion macros shared by the fader checks
`ifndef QUAD_STEPPED_SLEW_FADER_MACROS_SVH
`define QUAD_STEPPED_SLEW_FADER_MACROS_SVH

// check under reset qualification
`define QSSF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fader check failed");

// check that also holds while reset is low
`define QSSF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("fader check failed");

`endif

// File: sv/qssf_pkg.sv
// Types, constants and helpers of the quad stepped slew fader
package qssf_pkg;

    localparam int FADER_COUNT    = 4;
    localparam int UNITS_PER_CELL = 64;
    localparam int GRID_CELLS     = 64;
    localparam int LEVEL_W        = 33;
    localparam int FRAC_SHIFT     = 32 - $clog2(GRID_CELLS);
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int SLOW_W         = 25;
    localparam int FAST_W         = 32;
    localparam int PULSE_W        = 16;
    localparam int RATE_RESET     = 2;
    localparam int BAND_MAX       = 63;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SELECT = 3'd1;
    localparam logic [2:0] OP_ZOOM   = 3'd2;
    localparam logic [2:0] OP_RATE   = 3'd3;
    localparam logic [2:0] OP_PAD    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOWEST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FASTEST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE   = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] arg;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_a;
        logic [LEVEL_W-1:0] level_b;
        logic [LEVEL_W-1:0] level_c;
        logic [LEVEL_W-1:0] level_d;
        logic [3:0]         trigger_bits;
        logic [6:0]         fill_count;
        logic               zoom_on;
        logic [1:0]         shown_fader;
        logic [2:0]         rate_choice;
    } t_out_item;

    function automatic logic [2:0] rate_shift(input logic [2:0] rate);
        logic [2:0] sh;
        case (rate)
            3'd1:    sh = 3'd7;
            3'd2:    sh = 3'd5;
            3'd3:    sh = 3'd4;
            3'd4:    sh = 3'd3;
            3'd5:    sh = 3'd2;
            3'd6:    sh = 3'd1;
            default: sh = 3'd0;
        endcase
        return sh;
    endfunction

endpackage

// File: sv/quad_stepped_slew_fader.sv
// Four slewed faders with stepped pad entry, zoom view and arrival pulses
// A tick item steps every fader before the fill step; select, rate, zoom-off and
//   unknown items go straight to it; pad press and zoom-on pass the divider stages.
// Throughput: one item at a time; the next item is taken once the result is loaded.
// One add/compare unit visits the faders in turn on a tick, one per cycle.
// Synchronous active-low reset clears all fader state; rate resets to 2.
module quad_stepped_slew_fader #(
    parameter int FADER_COUNT    = qssf_pkg::FADER_COUNT,
    parameter int UNITS_PER_CELL = qssf_pkg::UNITS_PER_CELL
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  qssf_pkg::t_in_item                  i_in_item,
    output logic                                o_valid,
    input  logic                                i_stall,
    output qssf_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [qssf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [qssf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int LW          = qssf_pkg::LEVEL_W;
    localparam int TOTAL_UNITS = qssf_pkg::GRID_CELLS * UNITS_PER_CELL;
    localparam int UW          = $clog2(TOTAL_UNITS + 1);
    localparam int U1          = UW + 1;
    localparam int FW          = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;
    localparam int DIVD_W      = UW + qssf_pkg::FRAC_SHIFT;
    localparam int PW          = LW + UW;
    localparam int LIVE_W      = PW - 31;
    localparam int PULSE_W     = qssf_pkg::PULSE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_TICK = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    qssf_pkg::t_in_item             r_item;
    logic [FW-1:0]                  r_idx;
    logic [FW-1:0]                  r_cur;
    logic [2:0]                     r_rate;
    logic                           r_zoom;
    logic [5:0]                     r_band;
    logic [3:0]                     r_bits;
    logic                           r_dmode;
    logic [PW-1:0]                  r_prod;
    logic [qssf_pkg::SLOW_W-1:0]    r_slow;
    logic [qssf_pkg::FAST_W-1:0]    r_fast;
    logic [PULSE_W-1:0]             r_pulse_ticks;
    logic                           r_out_valid;
    qssf_pkg::t_out_item            r_out;

    logic [LW-1:0]                  r_level   [FADER_COUNT];
    logic [LW-1:0]                  r_tgt_lvl [FADER_COUNT];
    logic [UW-1:0]                  r_tgt_u   [FADER_COUNT];
    logic                           r_armed   [FADER_COUNT];
    logic [PULSE_W-1:0]             r_pulse   [FADER_COUNT];

    logic [FW-1:0]                  n_sel;
    logic [LW-1:0]                  n_v;
    logic [LW-1:0]                  n_t;
    logic [31:0]                    n_step;
    logic                           n_up;
    logic [LW-1:0]                  n_dist;
    logic                           n_hit;
    logic [LW-1:0]                  n_level;
    logic [PULSE_W-1:0]             n_p1;
    logic                           n_bit;
    logic [PULSE_W-1:0]             n_pulse;
    logic [U1-1:0]                  n_floor;
    logic [U1-1:0]                  n_ustep;
    logic [U1-1:0]                  n_cand0;
    logic [U1-1:0]                  n_raw;
    logic [U1-1:0]                  n_units;
    logic                           n_div_start;
    logic                           n_div_scale;
    logic [UW-1:0]                  n_div_units;
    logic                           w_done;
    logic [DIVD_W-1:0]              w_quot;
    logic [PW:0]                    n_round;
    logic [LIVE_W-1:0]              n_live;
    logic [LIVE_W-1:0]              n_base;
    logic [LIVE_W-1:0]              n_over;
    logic [LW:0]                    n_coarse_sum;
    logic [LW-26:0]                 n_coarse;
    logic [6:0]                     n_fill;
    logic                           n_load;

    assign n_sel = (r_state == S_TICK) ? r_idx : r_cur;

    // slew unit
    always_comb begin
        n_v    = r_level[n_sel];
        n_t    = r_tgt_lvl[n_sel];
        n_step = (r_rate == 3'd0) ? r_fast
               : (32'(r_slow) << qssf_pkg::rate_shift(r_rate));
        n_up   = n_t > n_v;
        n_dist = n_up ? (n_t - n_v) : (n_v - n_t);
        n_hit  = (n_v != n_t) && ({1'b0, n_dist} <= {2'b00, n_step});
        if (n_v == n_t) begin
            n_level = n_v;
        end else if (n_hit) begin
            n_level = n_t;
        end else if (n_up) begin
            n_level = n_v + LW'(n_step);
        end else begin
            n_level = n_v - LW'(n_step);
        end
        n_p1 = (n_hit && r_armed[n_sel] && (r_pulse_ticks > r_pulse[n_sel]))
             ? r_pulse_ticks : r_pulse[n_sel];
        n_bit   = n_p1 != '0;
        n_pulse = n_bit ? (n_p1 - PULSE_W'(1)) : n_p1;
    end

    // pad target
    always_comb begin
        n_floor = r_zoom ? U1'(r_band * UNITS_PER_CELL) : '0;
        n_ustep = r_zoom ? U1'(1) : U1'(UNITS_PER_CELL);
        n_cand0 = n_floor + n_ustep;
        if (r_item.arg == 6'd0) begin
            n_raw = (U1'(r_tgt_u[n_sel]) == n_cand0) ? n_floor : n_cand0;
        end else if (r_zoom) begin
            n_raw = n_floor + U1'(r_item.arg) + U1'(1);
        end else begin
            n_raw = n_floor + U1'((32'(r_item.arg) + 32'd1) * UNITS_PER_CELL);
        end
        n_units = (n_raw > U1'(TOTAL_UNITS)) ? U1'(TOTAL_UNITS) : n_raw;
    end

    always_comb begin
        n_div_start = 1'b0;
        n_div_scale = 1'b0;
        n_div_units = r_tgt_u[n_sel];
        if (r_state == S_EXEC) begin
            if (r_item.op == qssf_pkg::OP_PAD) begin
                n_div_start = 1'b1;
                n_div_scale = 1'b1;
                n_div_units = n_units[UW-1:0];
            end else if (r_item.op == qssf_pkg::OP_ZOOM && !r_zoom) begin
                n_div_start = 1'b1;
            end
        end
    end

    qssf_div #(
        .UNITS_W (UW),
        .SHIFT   (qssf_pkg::FRAC_SHIFT),
        .DIVISOR (UNITS_PER_CELL)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_scale    (n_div_scale),
        .i_units    (n_div_units),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    // fill count
    always_comb begin
        n_round      = {1'b0, r_prod} + (PW+1)'(33'h080000000);
        n_live       = n_round[PW:32];
        n_base       = LIVE_W'(r_band * UNITS_PER_CELL);
        n_over       = n_live - n_base;
        n_coarse_sum = {1'b0, n_v} + (LW+1)'(1 << (qssf_pkg::FRAC_SHIFT - 1));
        n_coarse     = n_coarse_sum[LW:26];
        if (r_zoom) begin
            if (n_live <= n_base) begin
                n_fill = 7'd0;
            end else if (n_over > LIVE_W'(qssf_pkg::GRID_CELLS)) begin
                n_fill = 7'(qssf_pkg::GRID_CELLS);
            end else begin
                n_fill = n_over[6:0];
            end
        end else if (n_coarse > (LW-25)'(qssf_pkg::GRID_CELLS)) begin
            n_fill = 7'(qssf_pkg::GRID_CELLS);
        end else begin
            n_fill = n_coarse[6:0];
        end
    end

    assign n_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_item.op == qssf_pkg::OP_TICK) begin
                    n_state = S_TICK;
                end else if (n_div_start) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_DIV: begin
                if (w_done) begin
                    n_state = S_FILL;
                end
            end
            S_TICK: begin
                if (r_idx == FW'(FADER_COUNT - 1)) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (n_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_cur         <= '0;
            r_rate        <= 3'(qssf_pkg::RATE_RESET);
            r_zoom        <= 1'b0;
            r_band        <= '0;
            r_bits        <= '0;
            r_dmode       <= 1'b0;
            r_slow        <= qssf_pkg::SLOW_W'(6087);
            r_fast        <= qssf_pkg::FAST_W'(97391548);
            r_pulse_ticks <= PULSE_W'(45);
            r_out_valid   <= 1'b0;
            for (int i = 0; i < FADER_COUNT; i++) begin
                r_level[i]   <= '0;
                r_tgt_lvl[i] <= '0;
                r_tgt_u[i]   <= '0;
                r_armed[i]   <= 1'b0;
                r_pulse[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    qssf_pkg::CFG_SLOWEST: r_slow        <= i_cfg_data[qssf_pkg::SLOW_W-1:0];
                    qssf_pkg::CFG_FASTEST: r_fast        <= i_cfg_data[qssf_pkg::FAST_W-1:0];
                    qssf_pkg::CFG_PULSE:   r_pulse_ticks <= i_cfg_data[PULSE_W-1:0];
                    default: ;
                endcase
            end
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_EXEC: begin
                    r_idx  <= '0;
                    r_bits <= '0;
                    case (r_item.op)
                        qssf_pkg::OP_SELECT: begin
                            if (r_item.arg < 6'(FADER_COUNT)) begin
                                r_cur  <= r_item.arg[FW-1:0];
                                r_zoom <= 1'b0;
                            end
                        end
                        qssf_pkg::OP_ZOOM: begin
                            r_dmode <= 1'b0;
                            if (r_zoom) begin
                                r_zoom <= 1'b0;
                            end
                        end
                        qssf_pkg::OP_RATE: begin
                            if (r_item.arg < 6'd8) begin
                                r_rate <= r_item.arg[2:0];
                            end
                        end
                        qssf_pkg::OP_PAD: begin
                            r_dmode        <= 1'b1;
                            r_tgt_u[n_sel] <= n_units[UW-1:0];
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    if (w_done) begin
                        if (r_dmode) begin
                            r_tgt_lvl[n_sel] <= w_quot[LW-1:0];
                            r_armed[n_sel]   <= w_quot != DIVD_W'(r_level[n_sel]);
                        end else begin
                            r_zoom <= 1'b1;
                            r_band <= (w_quot >= DIVD_W'(qssf_pkg::BAND_MAX))
                                    ? 6'(qssf_pkg::BAND_MAX) : w_quot[5:0];
                        end
                    end
                end
                S_TICK: begin
                    r_level[n_sel] <= n_level;
                    r_pulse[n_sel] <= n_pulse;
                    if (n_hit) begin
                        r_armed[n_sel] <= 1'b0;
                    end
                    for (int j = 0; j < 4; j++) begin
                        if (FW'(j) == r_idx && j < FADER_COUNT && n_bit) begin
                            r_bits[j] <= 1'b1;
                        end
                    end
                    r_idx <= r_idx + FW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_item <= i_in_item;
        end
        if (r_state == S_FILL) begin
            r_prod <= PW'(n_v) * PW'(TOTAL_UNITS);
        end
        if (n_load) begin
            r_out.level_a      <= (FADER_COUNT > 0) ? r_level[0] : '0;
            r_out.level_b      <= (FADER_COUNT > 1) ? r_level[(FADER_COUNT > 1) ? 1 : 0] : '0;
            r_out.level_c      <= (FADER_COUNT > 2) ? r_level[(FADER_COUNT > 2) ? 2 : 0] : '0;
            r_out.level_d      <= (FADER_COUNT > 3) ? r_level[(FADER_COUNT > 3) ? 3 : 0] : '0;
            r_out.trigger_bits <= r_bits;
            r_out.fill_count   <= n_fill;
            r_out.zoom_on      <= r_zoom;
            r_out.shown_fader  <= 2'(r_cur);
            r_out.rate_choice  <= r_rate;
        end
    end

    assign o_stall    = r_state != S_IDLE;
    assign o_valid    = r_out_valid;
    assign o_out_item = r_out;

endmodule

// File: sv/qssf_div.sv
// Division of a unit count by a constant cell size, by reciprocal multiplication in stages
module qssf_div #(
    parameter int UNITS_W = 13,
    parameter int SHIFT   = 26,
    parameter int DIVISOR = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_scale,
    input  logic [UNITS_W-1:0]       i_units,
    output logic                     o_done,
    output logic [UNITS_W+SHIFT-1:0] o_quot
);

    localparam int QW  = UNITS_W + SHIFT;
    localparam int DW  = $clog2(DIVISOR);
    localparam int XW  = UNITS_W + DW;
    localparam int RS  = XW + DW;
    localparam int PRW = XW + RS;
    localparam longint unsigned SCALE_Q = (64'd1 << SHIFT) / DIVISOR;
    localparam longint unsigned SCALE_R = (64'd1 << SHIFT) % DIVISOR;
    localparam longint unsigned RECIP   = ((64'd1 << RS) + DIVISOR - 1) / DIVISOR;

    logic [2:0]         r_stage;
    logic               r_done;
    logic               r_scale;
    logic [UNITS_W-1:0] r_units;
    logic [QW-1:0]      r_hi;
    logic [XW-1:0]      r_x;
    logic [XW-1:0]      r_lo;
    logic [QW-1:0]      r_quo;
    logic [PRW-1:0]     n_prod;

    assign n_prod = PRW'(r_x) * PRW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= {r_stage[1:0], i_start};
            r_done  <= r_stage[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_units <= i_units;
            r_scale <= i_scale;
        end
        if (r_stage[0]) begin
            r_hi <= r_scale ? (QW'(r_units) * QW'(SCALE_Q)) : '0;
            r_x  <= r_scale ? (XW'(r_units) * XW'(SCALE_R)) : XW'(r_units);
        end
        if (r_stage[1]) begin
            r_lo <= XW'(n_prod >> RS);
        end
        if (r_stage[2]) begin
            r_quo <= r_hi + QW'(r_lo);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: sv/qssf_checker.sv
// Port-level checks for the quad stepped slew fader, bound to the top level
`include "quad_stepped_slew_fader_macros.svh"

module qssf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input qssf_pkg::t_in_item               i_in_item,
    input logic                             o_valid,
    input logic                             i_stall,
    input qssf_pkg::t_out_item              o_out_item,
    input logic                             i_cfg_we,
    input logic [qssf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [qssf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    `QSSF_ASSERT(a_out_hold, (o_valid && i_stall) |=> (o_valid && $stable(o_out_item)))
    `QSSF_ASSERT(a_busy_after_accept, (i_valid && !o_stall) |=> o_stall)
    `QSSF_ASSERT(a_fill_range, o_valid |-> (o_out_item.fill_count <= 7'd64))
    `QSSF_ASSERT(a_result_from_work, $rose(o_valid) |-> $past(o_stall))
    `QSSF_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_valid && !o_stall))

endmodule

bind quad_stepped_slew_fader qssf_checker u_qssf_checker (.*);
